### rtl/crpc_pkg.sv
// Package for the command retry / poll controller.
// Holds payload structs, queue entry layout, request and register codes.
// No dependencies.
package crpc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_BITS  = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // request codes
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_ENQ   = 3'd1;
    localparam logic [2:0] REQ_REPLY = 3'd2;
    localparam logic [2:0] REQ_START = 3'd3;
    localparam logic [2:0] REQ_STOP  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_TMO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DLY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS  = 3'd5;

    // register reset values
    localparam logic [15:0] RST_RESP_TMO  = 16'd40;
    localparam logic [15:0] RST_RETRY_DLY = 16'd30;
    localparam logic [15:0] RST_POLL_INTV = 16'd10;
    localparam logic [7:0]  RST_ATTEMPTS  = 8'd3;

    typedef enum logic [1:0] {
        PH_STOPPED,
        PH_IDLE,
        PH_WAIT_REPLY,
        PH_RETRY
    } t_phase;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] cmd_token;
        logic        needs_response;
        logic        reply_ok;
        logic [7:0]  reply_dst;
        logic        reply_is_request;
    } t_item;

    typedef struct packed {
        logic                  send_valid;
        logic [15:0]           send_token;
        logic                  send_is_poll;
        logic                  send_wants_reply;
        logic                  restart_pulse;
        logic                  connected;
        logic [COUNT_BITS-1:0] sent_count;
        logic [COUNT_BITS-1:0] received_count;
        logic [COUNT_BITS-1:0] lost_count;
        logic [FILL_W-1:0]     queue_fill;
        logic                  enqueue_dropped;
    } t_result;

    typedef struct packed {
        logic [7:0]  host_id;
        logic [7:0]  device_id;
        logic [15:0] response_timeout_ms;
        logic [15:0] retry_delay_ms;
        logic [15:0] poll_interval_ms;
        logic [7:0]  attempts_before_restart;
    } t_cfg;

    typedef struct packed {
        logic        poll;
        logic        wants;
        logic [15:0] token;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry push_entry;
        logic   pop;
        logic   clear;
    } t_q_ctrl;

    // a zero timer setting acts as one tick
    function automatic logic [15:0] load_timer(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

### rtl/crpc_queue.sv
// Command queue storage: entry registers with tail write and head read.
// Depends on crpc_pkg; fill level is tracked by the controller.
module crpc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crpc_pkg::t_q_ctrl i_ctrl,
    output crpc_pkg::t_entry  o_head
);
    import crpc_pkg::*;

    t_entry           r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_ctrl.clear) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (i_ctrl.pop) begin
                r_head <= ptr_inc(r_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.clear) begin
            r_store[r_tail] <= i_ctrl.push_entry;
        end
    end

    assign o_head = r_store[r_head];

endmodule

### rtl/crpc_fsm.sv
// Link controller state machine: phase, timer, loss streak, fill, counters.
// Depends on crpc_pkg; drives crpc_queue and produces one result per event.
module crpc_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  crpc_pkg::t_item   i_item,
    input  crpc_pkg::t_cfg    i_cfg,
    input  crpc_pkg::t_entry  i_head,
    output crpc_pkg::t_q_ctrl o_q_ctrl,
    output crpc_pkg::t_result o_result
);
    import crpc_pkg::*;

    t_phase                r_phase, n_phase;
    logic [15:0]           r_timer, n_timer;
    logic                  r_adv, n_adv;
    logic [7:0]            r_streak, n_streak;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic                  r_link, n_link;
    logic [COUNT_BITS-1:0] r_sent, n_sent;
    logic [COUNT_BITS-1:0] r_recv, n_recv;
    logic [COUNT_BITS-1:0] r_lost, n_lost;

    logic        w_full;
    logic        w_push, w_pop, w_clear, w_send, w_drop, w_restart;
    logic        w_recv_inc, w_lost_inc;
    t_entry      w_new_entry;
    t_entry      w_head;
    logic [FILL_W-1:0] w_fill_push;
    logic        w_reply_valid;

    assign w_full = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_reply_valid = i_item.reply_ok && (i_item.reply_dst == i_cfg.host_id)
                           && !i_item.reply_is_request;

    // next state and event decisions
    always_comb begin
        logic send_req;
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_adv      = r_adv;
        n_streak   = r_streak;
        n_link     = r_link;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_clear    = 1'b0;
        w_send     = 1'b0;
        w_drop     = 1'b0;
        w_restart  = 1'b0;
        w_recv_inc = 1'b0;
        w_lost_inc = 1'b0;
        w_new_entry = '0;
        send_req   = 1'b0;

        case (i_item.req_type)
            REQ_TICK: begin
                case (r_phase)
                    PH_IDLE: begin
                        if (r_adv) begin
                            n_adv = 1'b0;
                            if (r_fill != '0) begin
                                send_req = 1'b1;
                            end else begin
                                n_timer = load_timer(i_cfg.poll_interval_ms);
                            end
                        end else if (r_timer <= 16'd1) begin
                            n_timer = '0;
                            if (!w_full) begin
                                w_push = 1'b1;
                                w_new_entry.poll  = 1'b1;
                                w_new_entry.wants = 1'b1;
                                n_adv = 1'b1;
                            end else begin
                                n_timer = load_timer(i_cfg.poll_interval_ms);
                            end
                        end else begin
                            n_timer = r_timer - 1'b1;
                        end
                    end
                    PH_WAIT_REPLY: begin
                        if (r_timer <= 16'd1) begin
                            w_lost_inc = 1'b1;
                            n_streak = r_streak + 1'b1;
                            if (n_streak >= i_cfg.attempts_before_restart) begin
                                n_streak  = '0;
                                n_link    = 1'b0;
                                w_restart = 1'b1;
                            end
                            n_phase = PH_RETRY;
                            n_timer = load_timer(i_cfg.retry_delay_ms);
                        end else begin
                            n_timer = r_timer - 1'b1;
                        end
                    end
                    PH_RETRY: begin
                        if (r_timer <= 16'd1) begin
                            n_timer = '0;
                            n_phase = PH_IDLE;
                            if (r_fill == '0) begin
                                n_adv   = 1'b0;
                                n_timer = load_timer(i_cfg.poll_interval_ms);
                            end else begin
                                n_adv = 1'b1;
                            end
                        end else begin
                            n_timer = r_timer - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_ENQ: begin
                w_new_entry.token = i_item.cmd_token;
                w_new_entry.wants = i_item.needs_response;
                if (w_full) begin
                    w_drop = 1'b1;
                end else begin
                    w_push = 1'b1;
                end
                if (r_phase == PH_IDLE) begin
                    send_req = 1'b1;
                end
            end
            REQ_REPLY: begin
                if (w_reply_valid) begin
                    w_recv_inc = 1'b1;
                    if (r_phase == PH_WAIT_REPLY) begin
                        n_link   = 1'b1;
                        n_streak = '0;
                        w_pop    = 1'b1;
                        n_timer  = '0;
                        n_phase  = PH_IDLE;
                        n_adv    = 1'b1;
                    end
                end
            end
            REQ_START: begin
                if (r_phase == PH_STOPPED) begin
                    n_phase = PH_IDLE;
                    if (r_fill == '0) begin
                        n_adv   = 1'b0;
                        n_timer = load_timer(i_cfg.poll_interval_ms);
                    end else begin
                        n_adv = 1'b1;
                    end
                end
            end
            REQ_STOP: begin
                n_phase = PH_STOPPED;
                w_clear = 1'b1;
                n_timer = '0;
                n_adv   = 1'b0;
                n_link  = 1'b0;
            end
            default: begin
            end
        endcase

        // send the head: a just-pushed entry is the head when the queue was empty
        w_fill_push = r_fill + FILL_W'(w_push);
        w_head      = (r_fill == '0) ? w_new_entry : i_head;
        if (send_req && (w_fill_push != '0)) begin
            w_send = 1'b1;
            n_adv  = 1'b0;
            if (w_head.wants) begin
                n_phase = PH_WAIT_REPLY;
                n_timer = load_timer(i_cfg.response_timeout_ms);
            end else begin
                w_pop   = 1'b1;
                n_phase = PH_IDLE;
                n_adv   = 1'b1;
            end
        end
    end

    // outputs, queue control and counters
    always_comb begin
        n_sent = w_send     ? r_sent + 1'b1 : r_sent;
        n_recv = w_recv_inc ? r_recv + 1'b1 : r_recv;
        n_lost = w_lost_inc ? r_lost + 1'b1 : r_lost;
        n_fill = w_clear ? '0 : w_fill_push - FILL_W'(w_pop);

        o_q_ctrl.push       = i_fire && w_push;
        o_q_ctrl.push_entry = w_new_entry;
        o_q_ctrl.pop        = i_fire && w_pop;
        o_q_ctrl.clear      = i_fire && w_clear;

        o_result = '0;
        if (w_send) begin
            o_result.send_valid       = 1'b1;
            o_result.send_token       = w_head.token;
            o_result.send_is_poll     = w_head.poll;
            o_result.send_wants_reply = w_head.wants;
        end
        o_result.restart_pulse   = w_restart;
        o_result.connected       = n_link;
        o_result.sent_count      = n_sent;
        o_result.received_count  = n_recv;
        o_result.lost_count      = n_lost;
        o_result.queue_fill      = n_fill;
        o_result.enqueue_dropped = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_STOPPED;
            r_timer  <= '0;
            r_adv    <= 1'b0;
            r_streak <= '0;
            r_fill   <= '0;
            r_link   <= 1'b0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_lost   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_adv    <= n_adv;
            r_streak <= n_streak;
            r_fill   <= n_fill;
            r_link   <= n_link;
            r_sent   <= n_sent;
            r_recv   <= n_recv;
            r_lost   <= n_lost;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_send_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_send) |-> (w_fill_push != '0))
        else $error("send from empty queue");

    a_restart_drops_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_restart) |=> (!r_link && r_phase == PH_RETRY))
        else $error("restart did not drop link");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.req_type == REQ_STOP) |=>
            (r_fill == '0 && r_phase == PH_STOPPED && !r_adv))
        else $error("stop did not clear state");

endmodule

### rtl/command_retry_poll_controller_top.sv
// Top level of the command retry / poll controller.
// Depends on crpc_pkg, crpc_queue and crpc_fsm.
//
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) carries one event
//   per transaction: a 1 ms tick, a command enqueue, an arrived reply, start
//   or stop. Output channel (o_out_valid / o_out_data / i_out_stall) returns
//   exactly one result transaction per event: the command sent (if any),
//   restart pulse, connected flag, counters, queue fill and drop flag.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_wdata while no event is in flight; writes take effect at once.
//
// Flow:
//   An accepted event is held in the input register, then the controller
//   state updates and the result is registered in the output register.
//   One event is processed every cycle while the output is not stalled.
//
// Reset: phase stopped, queue empty, link down, counters zero, registers at
//   their defaults. Queue entries are not cleared.
// Stall: a waiting result holds the output register; one more event is
//   taken into the input register, then o_in_stall rises until the output
//   is taken.
module command_retry_poll_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  crpc_pkg::t_item                     i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output crpc_pkg::t_result                   o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [crpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import crpc_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_data;
    logic    r_out_valid;
    t_result r_out_data;

    logic    w_adv;
    logic    w_fire;
    t_q_ctrl w_q_ctrl;
    t_entry  w_head;
    t_result w_result;

    // advance the event stage when the output register is free or being taken
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_id                 <= '0;
            r_cfg.device_id               <= '0;
            r_cfg.response_timeout_ms     <= RST_RESP_TMO;
            r_cfg.retry_delay_ms          <= RST_RETRY_DLY;
            r_cfg.poll_interval_ms        <= RST_POLL_INTV;
            r_cfg.attempts_before_restart <= RST_ATTEMPTS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOST_ID:   r_cfg.host_id                 <= i_cfg_wdata[7:0];
                CFG_DEVICE_ID: r_cfg.device_id               <= i_cfg_wdata[7:0];
                CFG_RESP_TMO:  r_cfg.response_timeout_ms     <= i_cfg_wdata;
                CFG_RETRY_DLY: r_cfg.retry_delay_ms          <= i_cfg_wdata;
                CFG_POLL_INTV: r_cfg.poll_interval_ms        <= i_cfg_wdata;
                CFG_ATTEMPTS:  r_cfg.attempts_before_restart <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register: hold while stalled, load on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    crpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_q_ctrl),
        .o_head  (w_head)
    );

    crpc_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .o_q_ctrl (w_q_ctrl),
        .o_result (w_result)
    );

    // result register: drop valid once taken, capture each processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sim/command_retry_poll_controller_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_retry_poll_controller_top: sends events over the
// valid/stall channel, predicts each status transaction locally and checks it in order.
// Depends on crpc_pkg and the RTL top level only.
module command_retry_poll_controller_top_tb;
    import crpc_pkg::*;

    localparam int REQ_CODE_MAX = 7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_item                 i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_result               o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    command_retry_poll_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow of the controller: registers, link state and command queue
    // ------------------------------------------------------------------
    t_cfg cfg_shadow = '{host_id: 8'd0, device_id: 8'd0,
                         response_timeout_ms: RST_RESP_TMO,
                         retry_delay_ms: RST_RETRY_DLY,
                         poll_interval_ms: RST_POLL_INTV,
                         attempts_before_restart: RST_ATTEMPTS};

    t_phase                lnk_phase  = PH_STOPPED;
    logic [15:0]           lnk_timer  = '0;
    logic                  lnk_adv    = 1'b0;
    logic [7:0]            lnk_streak = '0;
    logic                  lnk_up     = 1'b0;
    logic [COUNT_BITS-1:0] lnk_sent   = '0;
    logic [COUNT_BITS-1:0] lnk_recv   = '0;
    logic [COUNT_BITS-1:0] lnk_lost   = '0;
    t_entry                cmd_store [QUEUE_DEPTH];
    logic [PTR_W-1:0]      cmd_head   = '0;
    logic [PTR_W-1:0]      cmd_tail   = '0;
    logic [FILL_W-1:0]     cmd_fill   = '0;

    t_result pending_status [$];
    int      mismatch_count = 0;
    int      result_idx     = 0;
    bit      calm           = 1'b0;
    int      stall_left     = 0;
    int      run_left       = 0;

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_500_000;
        $display("command_retry_poll_controller_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // A zero timer setting behaves as a single tick.
    function automatic logic [15:0] ticks_of(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic bit cmdq_push(t_entry e);
        if (cmd_fill >= QUEUE_DEPTH) return 1'b0;
        cmd_store[cmd_tail] = e;
        cmd_tail = cmd_tail + 1'b1;
        cmd_fill = cmd_fill + 1'b1;
        return 1'b1;
    endfunction

    function automatic void cmdq_pop();
        if (cmd_fill == 0) return;
        cmd_head = cmd_head + 1'b1;
        cmd_fill = cmd_fill - 1'b1;
    endfunction

    // Put the queue head on the wire; hold it when a reply is due, else drop it.
    function automatic void transmit_head(inout t_result r);
        t_entry e;
        if (cmd_fill == 0) return;
        e = cmd_store[cmd_head];
        r.send_valid       = 1'b1;
        r.send_token       = e.token;
        r.send_is_poll     = e.poll;
        r.send_wants_reply = e.wants;
        lnk_sent = lnk_sent + 1'b1;
        lnk_adv  = 1'b0;
        if (e.wants) begin
            lnk_phase = PH_WAIT_REPLY;
            lnk_timer = ticks_of(cfg_shadow.response_timeout_ms);
        end else begin
            cmdq_pop();
            lnk_phase = PH_IDLE;
            lnk_adv   = 1'b1;
        end
    endfunction

    function automatic void enter_idle();
        lnk_phase = PH_IDLE;
        if (cmd_fill == 0) begin
            lnk_adv   = 1'b0;
            lnk_timer = ticks_of(cfg_shadow.poll_interval_ms);
        end else begin
            lnk_adv = 1'b1;
        end
    endfunction

    // Advance the shadow by one event and return the status it produces.
    function automatic t_result ctrl_step(t_item ev);
        t_result r;
        t_entry  e;
        r = '0;
        case (ev.req_type)
            REQ_TICK: begin
                if (lnk_phase == PH_IDLE) begin
                    if (lnk_adv) begin
                        lnk_adv = 1'b0;
                        if (cmd_fill > 0) transmit_head(r);
                        else lnk_timer = ticks_of(cfg_shadow.poll_interval_ms);
                    end else if (lnk_timer <= 1) begin
                        // poll countdown ran out: queue a status poll
                        lnk_timer = '0;
                        e = '{poll: 1'b1, wants: 1'b1, token: 16'd0};
                        if (cmdq_push(e)) lnk_adv = 1'b1;
                        else lnk_timer = ticks_of(cfg_shadow.poll_interval_ms);
                    end else begin
                        lnk_timer = lnk_timer - 1'b1;
                    end
                end else if (lnk_phase == PH_WAIT_REPLY) begin
                    if (lnk_timer <= 1) begin
                        lnk_timer  = '0;
                        lnk_streak = lnk_streak + 1'b1;
                        lnk_lost   = lnk_lost + 1'b1;
                        if (lnk_streak >= cfg_shadow.attempts_before_restart) begin
                            lnk_streak      = '0;
                            lnk_up          = 1'b0;
                            r.restart_pulse = 1'b1;
                        end
                        lnk_phase = PH_RETRY;
                        lnk_timer = ticks_of(cfg_shadow.retry_delay_ms);
                    end else begin
                        lnk_timer = lnk_timer - 1'b1;
                    end
                end else if (lnk_phase == PH_RETRY) begin
                    if (lnk_timer <= 1) begin
                        lnk_timer = '0;
                        enter_idle();
                    end else begin
                        lnk_timer = lnk_timer - 1'b1;
                    end
                end
            end
            REQ_ENQ: begin
                e = '{poll: 1'b0, wants: ev.needs_response, token: ev.cmd_token};
                if (!cmdq_push(e)) r.enqueue_dropped = 1'b1;
                if (lnk_phase == PH_IDLE) transmit_head(r);
            end
            REQ_REPLY: begin
                if (ev.reply_ok && ev.reply_dst == cfg_shadow.host_id &&
                    !ev.reply_is_request) begin
                    lnk_recv = lnk_recv + 1'b1;
                    if (lnk_phase == PH_WAIT_REPLY) begin
                        lnk_up     = 1'b1;
                        lnk_streak = '0;
                        cmdq_pop();
                        lnk_timer  = '0;
                        lnk_phase  = PH_IDLE;
                        lnk_adv    = 1'b1;
                    end
                end
            end
            REQ_START: begin
                if (lnk_phase == PH_STOPPED) enter_idle();
            end
            REQ_STOP: begin
                lnk_phase = PH_STOPPED;
                cmd_head  = '0;
                cmd_tail  = '0;
                cmd_fill  = '0;
                lnk_timer = '0;
                lnk_adv   = 1'b0;
                lnk_up    = 1'b0;
            end
            default: ;
        endcase
        r.connected      = lnk_up;
        r.sent_count     = lnk_sent;
        r.received_count = lnk_recv;
        r.lost_count     = lnk_lost;
        r.queue_fill     = cmd_fill;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("status %0d %s: got 0x%0h, want 0x%0h",
                                      result_idx, name, got, want));
    endtask

    // Sample at the falling edge: stall and valid are stable until the next rising edge,
    // where the transaction completes.
    always @(negedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_idx++;
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("status %0d arrived with nothing expected",
                                          result_idx));
            end else begin
                want = pending_status.pop_front();
                check_field("send_valid", 64'(o_out_data.send_valid),
                            64'(want.send_valid));
                check_field("send_token", 64'(o_out_data.send_token),
                            64'(want.send_token));
                check_field("send_is_poll", 64'(o_out_data.send_is_poll),
                            64'(want.send_is_poll));
                check_field("send_wants_reply", 64'(o_out_data.send_wants_reply),
                            64'(want.send_wants_reply));
                check_field("restart_pulse", 64'(o_out_data.restart_pulse),
                            64'(want.restart_pulse));
                check_field("connected", 64'(o_out_data.connected),
                            64'(want.connected));
                check_field("sent_count", 64'(o_out_data.sent_count),
                            64'(want.sent_count));
                check_field("received_count", 64'(o_out_data.received_count),
                            64'(want.received_count));
                check_field("lost_count", 64'(o_out_data.lost_count),
                            64'(want.lost_count));
                check_field("queue_fill", 64'(o_out_data.queue_fill),
                            64'(want.queue_fill));
                check_field("enqueue_dropped", 64'(o_out_data.enqueue_dropped),
                            64'(want.enqueue_dropped));
            end
        end
    end

    // Output backpressure: random stall bursts, each followed by a clear run.
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(0, 11);
            run_left   = $urandom_range(1, 30);
            i_out_stall <= 1'b1;
        end else begin
            run_left = $urandom_range(0, 29);
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_item make_event(logic [2:0] req, logic [15:0] token, logic needs,
                                         logic ok, logic [7:0] dst, logic is_req);
        t_item ev;
        ev.req_type         = req;
        ev.cmd_token        = token;
        ev.needs_response   = needs;
        ev.reply_ok         = ok;
        ev.reply_dst        = dst;
        ev.reply_is_request = is_req;
        return ev;
    endfunction

    function automatic t_item random_event(logic [2:0] req);
        return make_event(req, 16'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                          1'($urandom));
    endfunction

    // Offer one event, optionally after an idle burst; predict once it is taken.
    task automatic send_event(t_item ev);
        int gap;
        bit taken;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        pending_status.push_back(ctrl_step(ev));
    endtask

    // Drop valid and wait until every status is back and the pipe is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_HOST_ID:   cfg_shadow.host_id                 = val[7:0];
            CFG_DEVICE_ID: cfg_shadow.device_id               = val[7:0];
            CFG_RESP_TMO:  cfg_shadow.response_timeout_ms     = val;
            CFG_RETRY_DLY: cfg_shadow.retry_delay_ms          = val;
            CFG_POLL_INTV: cfg_shadow.poll_interval_ms        = val;
            CFG_ATTEMPTS:  cfg_shadow.attempts_before_restart = val[7:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(t_cfg c);
        settle();
        cfg_write(CFG_HOST_ID, {8'd0, c.host_id});
        cfg_write(CFG_DEVICE_ID, {8'd0, c.device_id});
        cfg_write(CFG_RESP_TMO, c.response_timeout_ms);
        cfg_write(CFG_RETRY_DLY, c.retry_delay_ms);
        cfg_write(CFG_POLL_INTV, c.poll_interval_ms);
        cfg_write(CFG_ATTEMPTS, {8'd0, c.attempts_before_restart});
    endtask

    // Mostly short timers so timeouts, retries and polls happen often.
    function automatic logic [15:0] random_delay();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r < 4) return 16'($urandom_range(7, 24));
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        int   r;
        c.host_id             = 8'($urandom);
        c.device_id           = 8'($urandom);
        c.response_timeout_ms = random_delay();
        c.retry_delay_ms      = random_delay();
        c.poll_interval_ms    = random_delay();
        r = $urandom_range(0, 9);
        if (r == 0) c.attempts_before_restart = 8'd0;
        else if (r == 1) c.attempts_before_restart = 8'd255;
        else c.attempts_before_restart = 8'($urandom_range(1, 5));
        return c;
    endfunction

    // Mostly ticks, enqueues and well-addressed replies; restart a stopped link quickly.
    function automatic t_item traffic_event();
        t_item ev;
        int    r;
        ev = random_event(REQ_TICK);
        r  = $urandom_range(0, 99);
        if (lnk_phase == PH_STOPPED && r < 60) begin
            ev.req_type = REQ_START;
        end else if (r < 45) begin
            ev.req_type = REQ_TICK;
        end else if (r < 68) begin
            ev.req_type = REQ_ENQ;
        end else if (r < 90) begin
            ev.req_type = REQ_REPLY;
            if ($urandom_range(0, 9) < 7) begin
                ev.reply_ok         = 1'b1;
                ev.reply_dst        = cfg_shadow.host_id;
                ev.reply_is_request = 1'b0;
            end
        end else if (r < 94) begin
            ev.req_type = REQ_START;
        end else if (r < 97) begin
            ev.req_type = REQ_STOP;
        end else begin
            ev.req_type = 3'($urandom_range(int'(REQ_STOP) + 1, REQ_CODE_MAX));
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Events while stopped: ticks do nothing, replies only count, unknown codes are
    // ignored, enqueues are stored without sending.
    task automatic test_stopped_events();
        send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_REPLY, 16'd0, 1'b0, 1'b1, 8'd0, 1'b0));
        for (int c = int'(REQ_STOP) + 1; c <= REQ_CODE_MAX; c++)
            send_event(make_event(3'(c), 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1));
        send_event(make_event(REQ_STOP, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_ENQ, 16'hFFFF, 1'b1, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_ENQ, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0));
    endtask

    // Start with a filled queue, repeat start, then filter bad replies before a good one.
    task automatic test_reply_filtering();
        send_event(make_event(REQ_START, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_START, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_REPLY, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_REPLY, 16'd0, 1'b0, 1'b1, 8'hFF, 1'b0));
        send_event(make_event(REQ_REPLY, 16'd0, 1'b0, 1'b1, 8'd0, 1'b1));
        send_event(make_event(REQ_REPLY, 16'd0, 1'b0, 1'b1, 8'd0, 1'b0));
        send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        // enqueue while idle goes out on the same step
        send_event(make_event(REQ_ENQ, 16'hA5A5, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_STOP, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
    endtask

    // Zero timers act as one tick and zero attempts restart on every loss.
    task automatic test_zero_registers();
        program_regs('{host_id: 8'hFF, device_id: 8'hFF, response_timeout_ms: 16'd0,
                       retry_delay_ms: 16'd0, poll_interval_ms: 16'd0,
                       attempts_before_restart: 8'd0});
        send_event(make_event(REQ_START, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        repeat (5) send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_REPLY, 16'd0, 1'b0, 1'b1, 8'hFF, 1'b0));
        send_event(make_event(REQ_STOP, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
    endtask

    // Largest settings: nothing expires within a few ticks.
    task automatic test_long_timers();
        program_regs('{host_id: 8'h00, device_id: 8'h00, response_timeout_ms: 16'hFFFF,
                       retry_delay_ms: 16'hFFFF, poll_interval_ms: 16'hFFFF,
                       attempts_before_restart: 8'hFF});
        send_event(make_event(REQ_START, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_ENQ, 16'h5A5A, 1'b1, 1'b0, 8'd0, 1'b0));
        repeat (2) send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(REQ_STOP, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
    endtask

    // Fill the queue while stopped; the enqueue past the depth is dropped.
    task automatic test_queue_overflow();
        program_regs(random_cfg());
        repeat (QUEUE_DEPTH + 1) send_event(random_event(REQ_ENQ));
        send_event(make_event(REQ_START, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
        repeat (3) send_event(make_event(REQ_TICK, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0));
    endtask

    // Phases of random traffic under random settings; the last one runs without idling.
    task automatic test_random_traffic();
        int burst_at;
        for (int ph = 0; ph < 8; ph++) begin
            program_regs(random_cfg());
            calm     = (ph == 7);
            burst_at = $urandom_range(0, 124);
            for (int k = 0; k < 125; k++) begin
                if (k == burst_at)
                    repeat ($urandom_range(4, 18)) send_event(random_event(REQ_ENQ));
                send_event(traffic_event());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stopped_events();
        test_reply_filtering();
        test_zero_registers();
        test_long_timers();
        test_queue_overflow();
        test_random_traffic();
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("command_retry_poll_controller_top test passed");
        end else begin
            $display("command_retry_poll_controller_top test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/crpc_pkg.sv
rtl/crpc_queue.sv
rtl/crpc_fsm.sv
rtl/command_retry_poll_controller_top.sv
sim/command_retry_poll_controller_top_tb.sv
